// ===== sv/clsr_pkg.sv =====
// Shared constants and types for the combined generator with shuffle table.
`default_nettype none

package clsr_pkg;

   // Default table depth
   localparam int unsigned TABLE_SIZE_DEF = 32;

   // Field widths
   localparam int unsigned WORD_W   = 31;
   localparam int unsigned FRAC_W   = 24;
   localparam int unsigned MUL_A_W  = 16;
   localparam int unsigned MUL_B_W  = 31;
   localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;

   // Generator constants
   localparam longint unsigned MOD1_L = 64'd2147483563;
   localparam logic [WORD_W-1:0] MOD1 = 31'd2147483563;
   localparam logic [WORD_W-1:0] MOD2 = 31'd2147483399;
   localparam logic [MUL_A_W-1:0] MUL1 = 16'd40014;
   localparam logic [MUL_A_W-1:0] MUL2 = 16'd40692;
   localparam logic [WORD_W-1:0] SEED_Y_RST = 31'd123456789;
   localparam logic [WORD_W:0] MOD1_LESS1 = 32'd2147483562;

   // 2^31 mod m: folds the bits above bit 30 back into the low word
   localparam logic [MUL_A_W-1:0] FOLD1 = 16'(32'h8000_0000 - 32'(MOD1));
   localparam logic [MUL_A_W-1:0] FOLD2 = 16'(32'h8000_0000 - 32'(MOD2));

   // Fraction clamp, just below one in Q0.24
   localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777214;

   // Product bit at which the slot reciprocal estimate starts
   localparam int unsigned SLOT_SHIFT = 37;

   // One operation for the shared multiplier
   typedef struct packed {
      logic                en;
      logic [MUL_A_W-1:0]  a;
      logic [MUL_B_W-1:0]  b;
   } mul_op_type;

endpackage

`default_nettype wire

// ===== sv/clsr_if.sv =====
// Request and response channel interfaces.
`default_nettype none

interface clsr_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [30:0] seed;

   modport source (output valid, output kind, output seed, input ready);
   modport sink   (input valid, input kind, input seed, output ready);
endinterface

interface clsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] value;
   logic [23:0] fraction;

   modport source (output valid, output value, output fraction, input ready);
   modport sink   (input valid, input value, input fraction, output ready);
endinterface

`default_nettype wire

// ===== sv/clsr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module clsr_ram #(
   parameter int unsigned WIDTH = clsr_pkg::WORD_W,
   parameter int unsigned DEPTH = clsr_pkg::TABLE_SIZE_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/clsr_mul.sv =====
// Shared 16 x 31 multiplier with registered product.
`default_nettype none

module clsr_mul (
   input  wire logic                       clock,
   input  wire clsr_pkg::mul_op_type       op,
   output      logic [clsr_pkg::PROD_W-1:0] prod
);

   logic [clsr_pkg::PROD_W-1:0] prod_ff;

   // Product register; holds when no operation is issued
   always_ff @(posedge clock) begin
      if (op.en) begin
         prod_ff <= {{clsr_pkg::MUL_B_W{1'b0}}, op.a} * {{clsr_pkg::MUL_A_W{1'b0}}, op.b};
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== sv/combined_lcg_shuffle_rng.sv =====
// Top level: combined congruential generator with shuffle table, sequencer and datapath.
`default_nettype none

// Two multiplicative congruential generators (moduli 2147483563 and 2147483399)
// combined through a shuffle table of TABLE_SIZE entries. A word with kind = 0
// draws one number; kind = 1 loads the seed (zero taken as one) into both
// generators, steps the first one TABLE_SIZE+8 times to fill the table, then
// draws. Every word returns one response word: the combined integer and its
// fraction of 2147483563 in Q0.24, clamped to 16777214. All multiplications run
// through one shared 16 x 31 multiplier with a registered product: a generator
// step goes through multiply, fold of the high bits, then add and reduce; the slot
// choice through estimate, check, fix with table read, then combine with table
// write; the fraction through multiply, then fix. A reseed adds TABLE_SIZE + 8
// first-generator steps. req ready is high only while the sequencer is idle, so
// a new word is not taken until the previous one has loaded the response register.
// A response waiting on rsp ready does not block acceptance; the final step waits
// only if the response register is still full. The table needs no clearing pass
// after reset: per-entry valid bits make unwritten slots read as zero.
module combined_lcg_shuffle_rng_core #(
   parameter int unsigned TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   clsr_req_if.sink   req_chan,
   clsr_rsp_if.source rsp_chan
);

   localparam int unsigned SLOT_W = $clog2(TABLE_SIZE);
   localparam int unsigned Q_W    = SLOT_W + 1;
   localparam int unsigned CNT_W  = $clog2(TABLE_SIZE + 8);
   localparam int unsigned W      = clsr_pkg::WORD_W;

   // Slot divisor and its reciprocal estimate
   localparam longint unsigned SLOT_DIV_L =
      64'd1 + (clsr_pkg::MOD1_L - 64'd1) / 64'(TABLE_SIZE);
   localparam longint unsigned SLOT_RECIP_L = (64'd1 << clsr_pkg::SLOT_SHIFT) / SLOT_DIV_L;
   localparam logic [W-1:0] SLOT_DIV = W'(SLOT_DIV_L);
   localparam logic [clsr_pkg::MUL_A_W-1:0] SLOT_RECIP = clsr_pkg::MUL_A_W'(SLOT_RECIP_L);
   localparam logic [Q_W:0] SLOT_LAST = (Q_W + 1)'(TABLE_SIZE - 1);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_GM   = 10'b00_0000_0010,  // generator multiply
      ST_GF   = 10'b00_0000_0100,  // fold high bits
      ST_GR   = 10'b00_0000_1000,  // add and reduce
      ST_SM   = 10'b00_0001_0000,  // slot estimate
      ST_SC   = 10'b00_0010_0000,  // slot check product
      ST_SF   = 10'b00_0100_0000,  // slot fix, table read
      ST_SR   = 10'b00_1000_0000,  // combine, table write
      ST_FM   = 10'b01_0000_0000,  // fraction multiply
      ST_FF   = 10'b10_0000_0000   // fraction fix, response
   } state_type;

   // Control registers
   state_type             state_ff, state_in;
   logic                  reseed_ff, reseed_in;
   logic                  gen_sel_ff, gen_sel_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [TABLE_SIZE-1:0] tbl_valid_ff, tbl_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]          x_ff, x_in;
   logic [W-1:0]          y_ff, y_in;
   logic [W-1:0]          last_ff, last_in;

   // Payload registers
   logic [W-1:0]          lo_ff;
   logic [Q_W-1:0]        q0_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic                  ent_valid_ff;
   logic [W-1:0]          rsp_value_ff;
   logic [clsr_pkg::FRAC_W-1:0] rsp_frac_ff;

   // Datapath nets
   clsr_pkg::mul_op_type        mul_op;
   logic [clsr_pkg::PROD_W-1:0] prod;
   logic [W-1:0]                gen_mod;
   logic [W:0]                  red_sum;
   logic [W-1:0]                red_res;
   logic [Q_W:0]                q_up;
   logic [Q_W:0]                q_fix;
   logic [SLOT_W-1:0]           slot;
   logic [W-1:0]                ram_rdata;
   logic [W-1:0]                entry;
   logic [W:0]                  diff;
   logic [W-1:0]                new_last;
   logic [W:0]                  frac_rem;
   logic [clsr_pkg::FRAC_W:0]   frac_q;
   logic [clsr_pkg::FRAC_W-1:0] frac;
   logic                        ram_we;
   logic [SLOT_W-1:0]           ram_waddr;
   logic [W-1:0]                ram_wdata;
   logic                        req_fire;
   logic                        out_free;
   logic [W-1:0]                seed_eff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign seed_eff = (req_chan.seed == '0) ? W'(1) : req_chan.seed;

   // Modular reduction: low word plus folded high part, one conditional subtract
   assign gen_mod = gen_sel_ff ? clsr_pkg::MOD2 : clsr_pkg::MOD1;
   assign red_sum = {1'b0, lo_ff} + prod[W:0];
   assign red_res = (red_sum >= {1'b0, gen_mod}) ? W'(red_sum - {1'b0, gen_mod})
                                                 : red_sum[W-1:0];

   // Slot: reciprocal estimate, corrected up by one where needed, then clamped
   assign q_up  = {1'b0, q0_ff} + (Q_W + 1)'(1);
   assign q_fix = ({{clsr_pkg::MUL_A_W{1'b0}}, last_ff} >= prod) ? q_up : {1'b0, q0_ff};
   assign slot  = (q_fix > SLOT_LAST) ? SLOT_LAST[SLOT_W-1:0] : q_fix[SLOT_W-1:0];

   // Combine table entry with second generator
   assign entry    = ent_valid_ff ? ram_rdata : '0;
   assign diff     = {1'b0, entry} - {1'b0, y_ff};
   assign new_last = (diff[W] || diff == '0) ? W'(diff + clsr_pkg::MOD1_LESS1)
                                             : diff[W-1:0];

   // Fraction: last >> 7 is the estimate; remainder decides one more
   assign frac_rem = {1'b0, last_ff[6:0], 24'd0} + prod[W:0];
   assign frac_q   = {1'b0, last_ff[W-1:7]} +
                     (clsr_pkg::FRAC_W + 1)'(frac_rem >= {1'b0, clsr_pkg::MOD1});
   assign frac     = (frac_q > {1'b0, clsr_pkg::FRAC_MAX}) ? clsr_pkg::FRAC_MAX
                                                           : frac_q[clsr_pkg::FRAC_W-1:0];

   // Shared multiplier operand selection
   always_comb begin
      mul_op = '0;
      case (state_ff)
         ST_GM: begin
            mul_op.en = 1'b1;
            mul_op.a  = gen_sel_ff ? clsr_pkg::MUL2 : clsr_pkg::MUL1;
            mul_op.b  = gen_sel_ff ? y_ff : x_ff;
         end
         ST_GF: begin
            mul_op.en = 1'b1;
            mul_op.a  = gen_sel_ff ? clsr_pkg::FOLD2 : clsr_pkg::FOLD1;
            mul_op.b  = W'(prod[clsr_pkg::PROD_W-1:W]);
         end
         ST_SM: begin
            mul_op.en = 1'b1;
            mul_op.a  = SLOT_RECIP;
            mul_op.b  = last_ff;
         end
         ST_SC: begin
            mul_op.en = 1'b1;
            mul_op.a  = clsr_pkg::MUL_A_W'(prod[clsr_pkg::SLOT_SHIFT +: Q_W]) +
                        clsr_pkg::MUL_A_W'(1);
            mul_op.b  = SLOT_DIV;
         end
         ST_FM: begin
            mul_op.en = 1'b1;
            mul_op.a  = clsr_pkg::FOLD1;
            mul_op.b  = W'(last_ff[W-1:7]);
         end
         default: begin
            mul_op = '0;
         end
      endcase
   end

   // Table write port: reseed fill or draw replacement
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = slot_ff;
      ram_wdata = x_ff;
      if (state_ff == ST_GR && reseed_ff && cnt_ff < CNT_W'(TABLE_SIZE)) begin
         ram_we    = 1'b1;
         ram_waddr = cnt_ff[SLOT_W-1:0];
         ram_wdata = red_res;
      end else if (state_ff == ST_SR) begin
         ram_we    = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      reseed_in    = reseed_ff;
      gen_sel_in   = gen_sel_ff;
      cnt_in       = cnt_ff;
      tbl_valid_in = tbl_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ram_we) begin
         tbl_valid_in[ram_waddr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               gen_sel_in = 1'b0;
               reseed_in  = req_chan.kind;
               state_in   = ST_GM;
               if (req_chan.kind) begin
                  x_in   = seed_eff;
                  y_in   = seed_eff;
                  cnt_in = CNT_W'(TABLE_SIZE + 7);
               end
            end
         end
         ST_GM: state_in = ST_GF;
         ST_GF: state_in = ST_GR;
         ST_GR: begin
            if (gen_sel_ff) begin
               y_in = red_res;
            end else begin
               x_in = red_res;
            end
            if (reseed_ff) begin
               state_in = ST_GM;
               if (cnt_ff == '0) begin
                  last_in   = red_res;
                  reseed_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end else if (!gen_sel_ff) begin
               gen_sel_in = 1'b1;
               state_in   = ST_GM;
            end else begin
               state_in = ST_SM;
            end
         end
         ST_SM: state_in = ST_SC;
         ST_SC: state_in = ST_SF;
         ST_SF: state_in = ST_SR;
         ST_SR: begin
            last_in  = new_last;
            state_in = ST_FM;
         end
         ST_FM: state_in = ST_FF;
         ST_FF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         reseed_ff    <= 1'b0;
         gen_sel_ff   <= 1'b0;
         cnt_ff       <= '0;
         tbl_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         x_ff         <= W'(1);
         y_ff         <= clsr_pkg::SEED_Y_RST;
         last_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         reseed_ff    <= reseed_in;
         gen_sel_ff   <= gen_sel_in;
         cnt_ff       <= cnt_in;
         tbl_valid_ff <= tbl_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         last_ff      <= last_in;
      end
   end

   // Datapath payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_GF) begin
         lo_ff <= prod[W-1:0];
      end
      if (state_ff == ST_SC) begin
         q0_ff <= prod[clsr_pkg::SLOT_SHIFT +: Q_W];
      end
      if (state_ff == ST_SF) begin
         slot_ff      <= slot;
         ent_valid_ff <= tbl_valid_ff[slot];
      end
      if (state_ff == ST_FF && out_free) begin
         rsp_value_ff <= last_ff;
         rsp_frac_ff  <= frac;
      end
   end

   clsr_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   clsr_ram #(
      .WIDTH (W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (slot),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.value    = rsp_value_ff;
   assign rsp_chan.fraction = rsp_frac_ff;

   // Checks
   a_tbl_wr_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_GR || state_ff == ST_SR))
      else $error("table written outside a write step");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_GM && gen_sel_ff == 1'b0))
      else $error("accepted word did not start a first-generator step");

   a_reseed_first: assert property (@(posedge clock) disable iff (reset)
      reseed_ff |-> (gen_sel_ff == 1'b0))
      else $error("second generator stepped during table fill");

   a_value_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff != '0))
      else $error("combined output is zero");

   a_frac_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_frac_ff <= clsr_pkg::FRAC_MAX))
      else $error("fraction above clamp");

endmodule

`default_nettype wire
